/* hw/rtl/pbds_pkg.sv */
// Shared types and constants for the packet buffer drop scheduler.
`default_nettype none

package pbds_pkg;

   localparam int DEPTH_DEF     = 64;
   localparam int TIME_BITS_DEF = 32;
   localparam int FIELD_BITS    = 32;
   localparam int CFG_BITS      = 7;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CFG_BITS-1:0] BUFFER_SIZE_RESET = 7'd1;

   typedef enum logic [0:0] {
      CSR_BUFFER_SIZE = 1'b0
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_CHECK,
      ST_EMIT
   } state_type;

endpackage : pbds_pkg

`default_nettype wire

/* hw/rtl/packet_buffer_drop_scheduler_unit.sv */
// Top level of the packet buffer drop scheduler: sequencer, state and config register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   req     | in        | req_valid/req_stall  | req_arrival_time, req_process_time
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_dropped, rsp_start_time
//   csr     | in/out    | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// An accepted word goes from idle to look and check, back to look for each buffered
// finish time retired, then to emit; each retirement is one RAM read and one compare.
// A new word is taken only in idle; a stalled result holds the sequencer in emit.
// Reset is synchronous and clears occupancy, ring pointers, last finish and buffer_size
// to 1; the finish ring holds no reset value.
`default_nettype none

module packet_buffer_drop_scheduler_unit
   import pbds_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [FIELD_BITS-1:0]    req_arrival_time,
   input  wire logic [FIELD_BITS-1:0]    req_process_time,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_dropped,
   output logic      [FIELD_BITS-1:0]    rsp_start_time,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   state_type state_ff, state_in;

   logic [CFG_BITS-1:0]  bs_ff, bs_in;
   logic [OW-1:0]        occ_ff, occ_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [AW-1:0]        tail_ff, tail_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [TIME_BITS-1:0] arr_ff, arr_in;
   logic [TIME_BITS-1:0] proc_ff, proc_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic                 drop_ff, drop_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_drop_ff, rsp_drop_in;
   logic [FIELD_BITS-1:0] rsp_start_ff, rsp_start_in;

   logic [TIME_BITS-1:0] arr_t, proc_t, rd_data, fin;
   logic [TIME_BITS:0]   fin_sum;
   logic [OW-1:0]        cap;
   logic                 csr_wr, req_take, slot_free, ram_wr;

   generate
      if (TIME_BITS >= FIELD_BITS) begin : g_wide
         assign arr_t  = TIME_BITS'(req_arrival_time);
         assign proc_t = TIME_BITS'(req_process_time);
      end else begin : g_narrow
         assign arr_t  = (|req_arrival_time[FIELD_BITS-1:TIME_BITS]) ?
                         '1 : req_arrival_time[TIME_BITS-1:0];
         assign proc_t = (|req_process_time[FIELD_BITS-1:TIME_BITS]) ?
                         '1 : req_process_time[TIME_BITS-1:0];
      end
   endgenerate

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == CSR_BUFFER_SIZE) ?
                   CSR_DATA_BITS'(bs_ff) : '0;

   always_comb begin
      if (bs_ff == '0) begin
         cap = OW'(1);
      end else if (32'(bs_ff) > DEPTH) begin
         cap = OW'(DEPTH);
      end else begin
         cap = OW'(bs_ff);
      end
   end

   assign fin_sum   = {1'b0, start_ff} + {1'b0, proc_ff};
   assign fin       = fin_sum[TIME_BITS] ? '1 : fin_sum[TIME_BITS-1:0];
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   pbds_ram #(
      .WIDTH     (TIME_BITS),
      .DEPTH     (DEPTH),
      .ADDR_BITS (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (tail_ff),
      .wr_data (fin),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bs_ff        <= BUFFER_SIZE_RESET;
         occ_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bs_ff        <= bs_in;
         occ_ff       <= occ_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      arr_ff       <= arr_in;
      proc_ff      <= proc_in;
      start_ff     <= start_in;
      drop_ff      <= drop_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_start_ff <= rsp_start_in;
   end

   always_comb begin
      state_in     = state_ff;
      bs_in        = bs_ff;
      occ_in       = occ_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      arr_in       = arr_ff;
      proc_in      = proc_ff;
      start_in     = start_ff;
      drop_in      = drop_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_start_in = rsp_start_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr       = 1'b0;

      if (csr_wr && (paddr[2] == CSR_BUFFER_SIZE)) begin
         bs_in = pwdata[CFG_BITS-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               arr_in   = arr_t;
               proc_in  = proc_t;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ((occ_ff != '0) && (rd_data <= arr_ff)) begin
               head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
               occ_in   = occ_ff - OW'(1);
               state_in = ST_LOOK;
            end else begin
               drop_in  = (occ_ff >= cap);
               start_in = (arr_ff > last_ff) ? arr_ff : last_ff;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_drop_in  = drop_ff;
               rsp_start_in = drop_ff ? '0 : FIELD_BITS'(start_ff);
               if (!drop_ff) begin
                  ram_wr  = 1'b1;
                  tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + AW'(1);
                  occ_in  = occ_ff + OW'(1);
                  last_in = fin;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dropped    = rsp_drop_ff;
   assign rsp_start_time = rsp_start_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= DEPTH)
      else $error("occupancy above ring depth");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> (rsp_start_time == '0))
      else $error("dropped word carries a start time");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      ram_wr |-> (occ_ff < cap))
      else $error("push into a full buffer");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && state_in == ST_LOOK) |-> (occ_ff != '0))
      else $error("retire from an empty buffer");

endmodule : packet_buffer_drop_scheduler_unit

`default_nettype wire

/* hw/rtl/pbds_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none

module pbds_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : pbds_ram

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the packet buffer drop scheduler unit.
module tb
   import pbds_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TAIL_CYCLES     = 3 + 2 * DEPTH_DEF + 8;
   localparam int PHASES          = 10;
   localparam int WORDS_PER_PHASE = 175;
   localparam int QUIET_PHASES    = 2;

   localparam logic [CSR_ADDR_BITS-1:0] BUFFER_SIZE_ADDR = {CSR_BUFFER_SIZE, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] UNMAPPED_ADDR    = {1'b1, 2'b00};
   localparam logic [FIELD_BITS-1:0]    TICK_MAX         = '1;

   typedef struct packed {
      logic                  dropped;
      logic [FIELD_BITS-1:0] start_time;
   } sched_result_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic [FIELD_BITS-1:0]    req_arrival_time = '0;
   logic [FIELD_BITS-1:0]    req_process_time = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic                     rsp_dropped;
   logic [FIELD_BITS-1:0]    rsp_start_time;
   logic                     psel             = 1'b0;
   logic                     penable          = 1'b0;
   logic                     pwrite           = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr            = '0;
   logic [CSR_DATA_BITS-1:0] pwdata           = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   packet_buffer_drop_scheduler_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_arrival_time (req_arrival_time),
      .req_process_time (req_process_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dropped      (rsp_dropped),
      .rsp_start_time   (rsp_start_time),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   logic [FIELD_BITS-1:0] finish_ring [DEPTH_DEF];
   logic [5:0]            ring_head   = '0;
   logic [6:0]            queued      = '0;
   logic [FIELD_BITS-1:0] last_finish = '0;
   logic [CFG_BITS-1:0]   buffer_size = BUFFER_SIZE_RESET;

   sched_result_type      expected_starts [$];
   int                    mismatches  = 0;
   bit                    allow_idle  = 1'b1;
   logic [FIELD_BITS-1:0] arrival_now = '0;

   function automatic sched_result_type schedule_packet(input logic [FIELD_BITS-1:0] arrival,
                                                        input logic [FIELD_BITS-1:0] service);
      sched_result_type    res;
      logic [CFG_BITS-1:0] cap;
      logic [FIELD_BITS:0] sum;
      logic [FIELD_BITS-1:0] start;
      logic [5:0]          slot;
      cap = buffer_size;
      if (cap == '0) cap = 7'd1;
      if (cap > 7'(DEPTH_DEF)) cap = 7'(DEPTH_DEF);
      while (queued != '0 && finish_ring[ring_head] <= arrival) begin
         ring_head = ring_head + 6'd1;
         queued    = queued - 7'd1;
      end
      if (queued >= cap) begin
         res.dropped    = 1'b1;
         res.start_time = '0;
         return res;
      end
      start = (arrival > last_finish) ? arrival : last_finish;
      sum   = {1'b0, start} + {1'b0, service};
      slot  = ring_head + queued[5:0];
      finish_ring[slot] = sum[FIELD_BITS] ? TICK_MAX : sum[FIELD_BITS-1:0];
      last_finish = finish_ring[slot];
      queued = queued + 7'd1;
      res.dropped    = 1'b0;
      res.start_time = start;
      return res;
   endfunction

   task automatic send_word(input logic [FIELD_BITS-1:0] arrival,
                            input logic [FIELD_BITS-1:0] service);
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_arrival_time <= arrival;
      req_process_time <= service;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_starts.push_back(schedule_packet(arrival, service));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_starts.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == BUFFER_SIZE_ADDR) buffer_size = data[CFG_BITS-1:0];
   endtask

   task automatic test_reset_capacity();
      send_word(32'd0, 32'd0);
      send_word(32'd0, 32'd5);
      send_word(32'd3, 32'd1);
      send_word(32'd5, 32'd2);
      send_word(32'd5, 32'd0);
   endtask

   task automatic test_capacity_extremes();
      wait_drained();
      csr_write(BUFFER_SIZE_ADDR, 32'd0);
      send_word(32'd10, 32'd3);
      send_word(32'd11, 32'd0);
      send_word(32'd13, 32'd1);
      wait_drained();
      csr_write(BUFFER_SIZE_ADDR, 32'd127);
      repeat (3) send_word(32'd20, 32'd100);
   endtask

   task automatic test_capacity_shrink();
      wait_drained();
      csr_write(BUFFER_SIZE_ADDR, 32'd4);
      repeat (4) send_word(32'd400, 32'd10);
      wait_drained();
      csr_write(BUFFER_SIZE_ADDR, 32'd1);
      send_word(32'd401, 32'd1);
      send_word(32'd410, 32'd1);
      send_word(32'd440, 32'd2);
   endtask

   task automatic test_unmapped_register();
      wait_drained();
      csr_write(UNMAPPED_ADDR, 32'd64);
      send_word(32'd500, 32'd10);
      send_word(32'd501, 32'd1);
   endtask

   task automatic test_random_traffic();
      logic [CFG_BITS-1:0] sizes [6];
      int unsigned         mean_service;
      int unsigned         gap_max;
      int unsigned         pick;
      logic [FIELD_BITS-1:0] arrival;
      logic [FIELD_BITS-1:0] service;
      sizes = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd65, 7'd1};
      arrival_now = 32'd600;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         allow_idle = (phase < PHASES - QUIET_PHASES) && ($urandom_range(0, 4) != 0);
         csr_write(BUFFER_SIZE_ADDR,
                   (phase < 6) ? 32'(sizes[phase]) : 32'($urandom_range(0, 127)));
         arrival_now  = arrival_now + $urandom_range(0, 32'h0800_0000);
         mean_service = $urandom_range(1, 48);
         gap_max      = $urandom_range(0, 4 * mean_service);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            pick    = $urandom_range(0, 9);
            service = $urandom_range(0, 2 * mean_service);
            if (pick == 0) begin
               arrival = (arrival_now > 64) ? arrival_now - $urandom_range(0, 64) : '0;
            end else if (pick == 1) begin
               arrival_now = arrival_now + $urandom_range(0, 4000);
               arrival     = arrival_now;
            end else if (pick == 2) begin
               arrival_now = arrival_now + $urandom_range(0, gap_max);
               arrival     = arrival_now;
               service     = '0;
            end else begin
               arrival_now = arrival_now + $urandom_range(0, gap_max);
               arrival     = arrival_now;
            end
            send_word(arrival, service);
         end
      end
   endtask

   task automatic test_time_saturation();
      wait_drained();
      allow_idle = 1'b0;
      csr_write(BUFFER_SIZE_ADDR, 32'd4);
      send_word(32'hFFFF_FFF0, 32'h0000_0010);
      send_word(32'hFFFF_FFF8, 32'd0);
      send_word(32'h0000_1234, 32'd5);
      send_word(TICK_MAX, TICK_MAX);
      repeat (5) send_word(32'd0, TICK_MAX);
      send_word(TICK_MAX, 32'd0);
   endtask

   int unsigned burst_left = 0;

   always @(posedge clock) begin
      if (reset || !allow_idle) begin
         rsp_stall  <= 1'b0;
         burst_left = 0;
      end else begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         burst_left = burst_left - 1;
      end
   end

   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_starts.size() == 0) begin
            $display("%0t: unexpected word dropped=%0d start_time=%0d",
                     $time, rsp_dropped, rsp_start_time);
            mismatches++;
         end else begin
            want = expected_starts.pop_front();
            if (rsp_dropped !== want.dropped) begin
               $display("%0t: dropped expected %0d actual %0d",
                        $time, want.dropped, rsp_dropped);
               mismatches++;
            end
            if (rsp_start_time !== want.start_time) begin
               $display("%0t: start_time expected %0d actual %0d",
                        $time, want.start_time, rsp_start_time);
               mismatches++;
            end
         end
      end
   end

   int unsigned stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles = stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_capacity();
      test_capacity_extremes();
      test_capacity_shrink();
      test_unmapped_register();
      test_random_traffic();
      test_time_saturation();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_starts.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
